[hw/rtl/ssd_pkg.sv]
// Package for the serial set-point digit display.
// Holds the input and job codes, character constants, the job record and the segment table.
// Depends on nothing.
`default_nettype none

package ssd_pkg;

	typedef enum logic [2:0] {
		KIND_RX     = 3'd0,
		KIND_SELECT = 3'd1,
		KIND_DOWN   = 3'd2,
		KIND_UP     = 3'd3,
		KIND_SCAN   = 3'd4
	} kind_t;

	typedef enum logic [1:0] {
		JOB_ECHO = 2'd0,
		JOB_SEND = 2'd1,
		JOB_SCAN = 2'd2
	} job_kind_t;

	localparam logic REG_BLANK_COUNT  = 1'b0;
	localparam logic REG_BLINK_PERIOD = 1'b1;

	localparam logic [7:0] CH_AMP    = 8'h26;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_AT     = 8'h40;
	localparam logic [7:0] CH_HASH   = 8'h23;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;

	localparam logic [7:0] SEG_DARK  = 8'hFF;
	localparam logic [7:0] SEG_POINT = 8'h7F;

	localparam int MaxDigits = 8;
	localparam int JobPosW   = 4;
	localparam int JobQDepth = 2;
	localparam int JobQPtrW  = $clog2(JobQDepth);
	localparam int JobQCntW  = $clog2(JobQDepth + 1);

	typedef struct packed {
		job_kind_t                  kind;
		logic [MaxDigits-1:0][3:0]  digits;
		logic [JobPosW-1:0]         blank_pos;
		logic                       ind;
	} job_t;

	function automatic logic [7:0] seg_decode(input logic [3:0] d);
		logic [7:0] s;
		case (d)
			4'd0: s = 8'hC0;
			4'd1: s = 8'hF9;
			4'd2: s = 8'hA4;
			4'd3: s = 8'hB0;
			4'd4: s = 8'h99;
			4'd5: s = 8'h92;
			4'd6: s = 8'h82;
			4'd7: s = 8'hF8;
			4'd8: s = 8'h80;
			4'd9: s = 8'h90;
			default: s = SEG_DARK;
		endcase
		return s;
	endfunction

endpackage

`default_nettype wire

[hw/rtl/ssd_front.sv]
// Front part of the serial set-point digit display: takes items, updates the display state
// and the configuration registers, and hands jobs with a snapshot of the state to the queue.
// Depends on ssd_pkg.
`default_nettype none

module ssd_front import ssd_pkg::*; #(
	parameter int NUM_DIGITS = 5
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push,
	input  wire logic [2:0]   kind,
	input  wire logic [7:0]   rx_byte,
	input  wire logic         cfg_we,
	input  wire logic [1:0]   cfg_index,
	input  wire logic [7:0]   cfg_data,
	input  wire logic         q_full,
	output job_t              job,
	output logic              job_push
);

	localparam int PW = $clog2(NUM_DIGITS + 1);
	localparam logic [PW-1:0] LastPos = PW'(NUM_DIGITS);

	logic [3:0]    digit_q [NUM_DIGITS];
	logic [3:0]    digit_n [NUM_DIGITS];
	logic [PW-1:0] sel_q, sel_n;
	logic [PW-1:0] frame_q, frame_n;
	logic [7:0]    blink_q, blink_n, blink_inc;
	logic          ind_q, ind_n;
	logic [7:0]    blank_count_q, blink_period_q;
	logic          accept, dark, want_push;
	logic [3:0]    d_old;

	assign accept   = push && !q_full;
	assign job_push = accept && want_push;

	always_comb begin
		for (int i = 0; i < NUM_DIGITS; i++) begin
			digit_n[i] = digit_q[i];
		end
		sel_n     = sel_q;
		frame_n   = frame_q;
		blink_n   = blink_q;
		blink_inc = blink_q + 8'd1;
		ind_n     = ind_q;
		dark      = 1'b0;
		want_push = 1'b0;
		d_old     = 4'd0;
		job.kind  = JOB_ECHO;
		case (kind)
			KIND_RX: begin
				if (rx_byte == CH_LPAREN) begin
					ind_n = 1'b1;
				end
				if (rx_byte == CH_RPAREN) begin
					ind_n = 1'b0;
				end
				if (rx_byte == CH_AT) begin
					frame_n = '0;
					sel_n   = '0;
				end
				if (frame_n != '0) begin
					for (int i = 0; i < NUM_DIGITS; i++) begin
						if (frame_n == PW'(i + 1)) begin
							digit_n[i] = (rx_byte >= CH_ZERO && rx_byte <= CH_NINE) ?
								rx_byte[3:0] : 4'd0;
						end
					end
					frame_n = (frame_n >= LastPos) ? '0 : frame_n + PW'(1);
				end
				if (rx_byte == CH_HASH) begin
					frame_n = PW'(1);
				end
				if (rx_byte == CH_AMP) begin
					want_push = 1'b1;
					job.kind  = JOB_ECHO;
				end
			end
			KIND_SELECT: begin
				sel_n = (sel_q >= LastPos) ? '0 : sel_q + PW'(1);
			end
			KIND_DOWN, KIND_UP: begin
				for (int i = 0; i < NUM_DIGITS; i++) begin
					if (sel_q == PW'(i + 1)) begin
						d_old = digit_q[i];
						if (kind == KIND_UP) begin
							digit_n[i] = (d_old >= 4'd9) ? 4'd0 : d_old + 4'd1;
						end else begin
							digit_n[i] = (d_old == 4'd0 || d_old > 4'd9) ? 4'd9 : d_old - 4'd1;
						end
					end
				end
				want_push = 1'b1;
				job.kind  = JOB_SEND;
			end
			KIND_SCAN: begin
				if (sel_q != '0 && sel_q <= LastPos) begin
					if (blink_inc <= blank_count_q) begin
						dark    = 1'b1;
						blink_n = blink_inc;
					end else if (blink_inc > blink_period_q) begin
						blink_n = 8'd0;
					end else begin
						blink_n = blink_inc;
					end
				end
				want_push = 1'b1;
				job.kind  = JOB_SCAN;
			end
			default: begin
			end
		endcase
		job.digits = '0;
		for (int i = 0; i < NUM_DIGITS; i++) begin
			job.digits[i] = digit_n[i];
		end
		job.blank_pos = dark ? JobPosW'(sel_q) : '0;
		job.ind       = ind_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_DIGITS; i++) begin
				digit_q[i] <= 4'd0;
			end
			sel_q   <= '0;
			frame_q <= '0;
			blink_q <= 8'd0;
			ind_q   <= 1'b0;
		end else if (accept) begin
			for (int i = 0; i < NUM_DIGITS; i++) begin
				digit_q[i] <= digit_n[i];
			end
			sel_q   <= sel_n;
			frame_q <= frame_n;
			blink_q <= blink_n;
			ind_q   <= ind_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blank_count_q  <= 8'd50;
			blink_period_q <= 8'd100;
		end else if (cfg_we && cfg_index[1] == 1'b0) begin
			if (cfg_index[0] == REG_BLANK_COUNT) begin
				blank_count_q <= cfg_data;
			end else if (cfg_index[0] == REG_BLINK_PERIOD) begin
				blink_period_q <= cfg_data;
			end
		end
	end

endmodule

`default_nettype wire

[hw/rtl/ssd_job_queue.sv]
// Short job queue between the front and back parts of the digit display.
// Depends on ssd_pkg for the job record and the queue depth.
`default_nettype none

module ssd_job_queue import ssd_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  job_t       wr_job,
	input  wire logic  wr_en,
	output logic       full,
	output job_t       rd_job,
	output logic       rd_valid,
	input  wire logic  rd_en
);

	job_t                mem_q [JobQDepth];
	logic [JobQPtrW-1:0] wr_ptr_q, rd_ptr_q;
	logic [JobQCntW-1:0] cnt_q;
	logic                do_wr, do_rd;

	assign full     = (cnt_q == JobQCntW'(JobQDepth));
	assign rd_valid = (cnt_q != '0);
	assign rd_job   = mem_q[rd_ptr_q];
	assign do_wr    = wr_en && !full;
	assign do_rd    = rd_en && rd_valid;

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == JobQPtrW'(JobQDepth - 1)) ? '0 : wr_ptr_q + JobQPtrW'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == JobQPtrW'(JobQDepth - 1)) ? '0 : rd_ptr_q + JobQPtrW'(1);
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + JobQCntW'(1);
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - JobQCntW'(1);
			end
		end
	end

endmodule

`default_nettype wire

[hw/rtl/ssd_back.sv]
// Back part of the digit display: expands each job into its result beats, one a cycle
// while the receiver keeps popping, into an output register. Depends on ssd_pkg.
`default_nettype none

module ssd_back import ssd_pkg::*; #(
	parameter int NUM_DIGITS = 5
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  job_t             job,
	input  wire logic        job_valid,
	output logic             job_pop,
	output logic             out_valid,
	input  wire logic        pop,
	output logic             result_kind,
	output logic [7:0]       tx_byte,
	output logic [2:0]       digit_index,
	output logic [7:0]       segments,
	output logic             indicator_on,
	output logic             last
);

	localparam int PW = $clog2(NUM_DIGITS + 1);

	logic [PW-1:0] cnt_q;
	logic          out_v_q;
	logic          ld, r_last, r_kind;
	logic [7:0]    r_tx, r_seg;
	logic [3:0]    d;

	assign out_valid = out_v_q;
	assign ld        = job_valid && (!out_v_q || pop);
	assign job_pop   = ld && r_last;

	always_comb begin
		d      = job.digits[3'(cnt_q)];
		r_kind = 1'b0;
		r_tx   = 8'd0;
		r_seg  = SEG_DARK;
		r_last = 1'b1;
		case (job.kind)
			JOB_ECHO: begin
				r_tx = CH_AMP;
			end
			JOB_SEND: begin
				r_last = (cnt_q == PW'(NUM_DIGITS));
				if (r_last) begin
					r_tx = CH_AT;
				end else begin
					r_tx = CH_ZERO | {4'd0, ((d > 4'd9) ? 4'd0 : d)};
				end
			end
			JOB_SCAN: begin
				r_kind = 1'b1;
				r_last = (cnt_q == PW'(NUM_DIGITS - 1));
				if (job.blank_pos != JobPosW'(cnt_q) + JobPosW'(1)) begin
					r_seg = seg_decode(d);
					if (cnt_q == PW'(1)) begin
						r_seg = r_seg & SEG_POINT;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			cnt_q   <= '0;
		end else if (ld) begin
			out_v_q <= 1'b1;
			cnt_q   <= r_last ? '0 : cnt_q + PW'(1);
		end else if (pop) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ld) begin
			result_kind  <= r_kind;
			tx_byte      <= r_tx;
			digit_index  <= (job.kind == JOB_SCAN) ? 3'(cnt_q) : 3'd0;
			segments     <= r_seg;
			indicator_on <= job.ind;
			last         <= r_last;
		end
	end

endmodule

`default_nettype wire

[hw/rtl/serial_set_digit_display.sv]
// Top level of the serial set-point digit display.
// Joins the front part, the job queue and the back part; depends on ssd_pkg.
//
// Items enter through push/full: kind 0 is a received serial byte, 1 select, 2 down, 3 up,
// 4 scan. Results leave through empty/pop, oldest first, with last high on the final
// beat of each item. Configuration writes go through cfg_valid/cfg_ready, which is
// always ready; index 0 is the blank count and index 1 the blink period.
// The front part takes one item a cycle while the two-entry job queue has room, so
// full rises only when the back part falls behind. The first result of an item passes
// through a queue entry and then the output register. The back part issues one beat a
// cycle while the receiver keeps popping: one for an echo, NUM_DIGITS for a scan and
// NUM_DIGITS+1 for up or down, so the sustained rate is set by that beat count. When
// the receiver stalls, the output register holds its beat, the queue fills and full is
// raised; nothing is dropped. Reset clears the digits, selection, frame position, blink
// counter and indicator, empties the queue and restores the register defaults.
`default_nettype none

module serial_set_digit_display import ssd_pkg::*; #(
	parameter int NUM_DIGITS = 5
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       push,
	output logic            full,
	input  wire logic [2:0] kind,
	input  wire logic [7:0] rx_byte,
	output logic            empty,
	input  wire logic       pop,
	output logic            result_kind,
	output logic [7:0]      tx_byte,
	output logic [2:0]      digit_index,
	output logic [7:0]      segments,
	output logic            indicator_on,
	output logic            last,
	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic [1:0] cfg_index,
	input  wire logic [7:0] cfg_data
);

	job_t front_job, back_job;
	logic front_push, q_full, back_valid, back_pop, out_valid;

	assign cfg_ready = 1'b1;
	assign full      = q_full;
	assign empty     = !out_valid;

	ssd_front #(
		.NUM_DIGITS(NUM_DIGITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.kind     (kind),
		.rx_byte  (rx_byte),
		.cfg_we   (cfg_valid),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.q_full   (q_full),
		.job      (front_job),
		.job_push (front_push)
	);

	ssd_job_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_job  (front_job),
		.wr_en   (front_push),
		.full    (q_full),
		.rd_job  (back_job),
		.rd_valid(back_valid),
		.rd_en   (back_pop)
	);

	ssd_back #(
		.NUM_DIGITS(NUM_DIGITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.job         (back_job),
		.job_valid   (back_valid),
		.job_pop     (back_pop),
		.out_valid   (out_valid),
		.pop         (pop),
		.result_kind (result_kind),
		.tx_byte     (tx_byte),
		.digit_index (digit_index),
		.segments    (segments),
		.indicator_on(indicator_on),
		.last        (last)
	);

endmodule

`default_nettype wire

[dv/tb.sv]
// Self-checking testbench for the serial set-point digit display.
// Drives directed and random items through the push/full and pop/empty queues and
// checks every result beat against its own predictor or directed table; depends on ssd_pkg and the RTL.
`timescale 1ns / 100ps

module tb;
	import ssd_pkg::*;

	localparam int NDIG         = 5;
	localparam int DRAIN_CYCLES = 8;
	localparam int END_CYCLES   = 20;
	localparam int HOLD_CYCLES  = 300;
	localparam int CYCLE_LIMIT  = 400000;

	localparam logic [2:0] KIND_SPARE_A = 3'd5;
	localparam logic [2:0] KIND_SPARE_B = 3'd6;
	localparam logic [2:0] KIND_SPARE_C = 3'd7;

	localparam logic RES_TX  = 1'b0;
	localparam logic RES_SEG = 1'b1;

	localparam logic [1:0] IDX_BLANK  = {1'b0, REG_BLANK_COUNT};
	localparam logic [1:0] IDX_PERIOD = {1'b0, REG_BLINK_PERIOD};

	localparam logic [9:0][7:0] GLYPHS = {
		8'h90, 8'h80, 8'hF8, 8'h82, 8'h92, 8'h99, 8'hB0, 8'hA4, 8'hF9, 8'hC0
	};

	typedef struct packed {
		logic       rk;
		logic [7:0] tx;
		logic [2:0] idx;
		logic [7:0] seg;
		logic       ind;
		logic       lst;
	} beat_t;

	typedef struct {
		logic [2:0] k;
		logic [7:0] b;
		bit         typed;
		bit         has_beat;
		logic [7:0] tx;
		logic       ind;
	} stim_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       push = 1'b0;
	logic [2:0] kind = 3'd0;
	logic [7:0] rx_byte = 8'd0;
	logic       pop = 1'b0;
	logic       cfg_valid = 1'b0;
	logic [1:0] cfg_index = 2'd0;
	logic [7:0] cfg_data = 8'd0;
	logic       full, empty, cfg_ready;
	logic       result_kind, indicator_on, last;
	logic [7:0] tx_byte, segments;
	logic [2:0] digit_index;

	logic [3:0] digits [NDIG];
	logic [2:0] sel_pos;
	logic [2:0] frame_pos;
	logic [7:0] blink_cnt;
	logic       ind_flag;
	logic [7:0] blank_cnt;
	logic [7:0] blink_per;

	beat_t expected_beats[$];
	beat_t fresh_beats[$];
	stim_t table_rows[$];
	int    mismatches = 0;
	int    cycle_count = 0;
	int    idle_pct = 0;
	bit    hold_out = 0;

	serial_set_digit_display #(.NUM_DIGITS(NDIG)) u_top (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .kind(kind),
		.rx_byte(rx_byte), .empty(empty), .pop(pop), .result_kind(result_kind),
		.tx_byte(tx_byte), .digit_index(digit_index), .segments(segments),
		.indicator_on(indicator_on), .last(last), .cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #2 clk = ~clk;

	task automatic predict_display(input logic [2:0] k, input logic [7:0] b);
		logic [3:0] d;
		logic [7:0] seg;
		bit         lit;
		fresh_beats.delete();
		case (k)
			KIND_RX: begin
				if (b == CH_LPAREN) ind_flag = 1'b1;
				if (b == CH_RPAREN) ind_flag = 1'b0;
				if (b == CH_AT) begin
					frame_pos = 3'd0;
					sel_pos = 3'd0;
				end
				if (frame_pos >= 1 && frame_pos <= NDIG) begin
					digits[frame_pos - 3'd1] = (b >= CH_ZERO && b <= CH_NINE) ?
						4'(b - CH_ZERO) : 4'd0;
					frame_pos = (frame_pos == NDIG) ? 3'd0 : frame_pos + 3'd1;
				end
				if (b == CH_HASH) frame_pos = 3'd1;
				if (b == CH_AMP)
					fresh_beats.push_back('{RES_TX, CH_AMP, 3'd0, SEG_DARK, ind_flag, 1'b1});
			end
			KIND_SELECT: sel_pos = (sel_pos >= NDIG) ? 3'd0 : sel_pos + 3'd1;
			KIND_DOWN, KIND_UP: begin
				if (sel_pos >= 1 && sel_pos <= NDIG) begin
					d = digits[sel_pos - 3'd1];
					if (k == KIND_UP) d = (d >= 9) ? 4'd0 : d + 4'd1;
					else d = (d == 0 || d > 9) ? 4'd9 : d - 4'd1;
					digits[sel_pos - 3'd1] = d;
				end
				for (int i = 0; i < NDIG; i++) begin
					d = (digits[i] > 9) ? 4'd0 : digits[i];
					fresh_beats.push_back('{RES_TX, CH_ZERO + {4'd0, d}, 3'd0, SEG_DARK,
						ind_flag, 1'b0});
				end
				fresh_beats.push_back('{RES_TX, CH_AT, 3'd0, SEG_DARK, ind_flag, 1'b1});
			end
			KIND_SCAN: begin
				for (int i = 0; i < NDIG; i++) begin
					lit = 1;
					if (sel_pos == i + 1) begin
						blink_cnt = blink_cnt + 8'd1;
						if (blink_cnt <= blank_cnt) lit = 0;
						else if (blink_cnt > blink_per) blink_cnt = 8'd0;
					end
					if (lit) begin
						seg = GLYPHS[digits[i]];
						if (i == 1) seg = seg & SEG_POINT;
					end else begin
						seg = SEG_DARK;
					end
					fresh_beats.push_back('{RES_SEG, 8'd0, 3'(i), seg, ind_flag,
						logic'(i == NDIG - 1)});
				end
			end
			default: ;
		endcase
	endtask

	task automatic send_item(input stim_t s);
		push <= 1'b1;
		kind <= s.k;
		rx_byte <= s.b;
		@(posedge clk);
		while (full) @(posedge clk);
		predict_display(s.k, s.b);
		if (s.typed) begin
			if (s.has_beat)
				expected_beats.push_back('{RES_TX, s.tx, 3'd0, SEG_DARK, s.ind, 1'b1});
		end else begin
			foreach (fresh_beats[i]) expected_beats.push_back(fresh_beats[i]);
		end
		if ($urandom_range(0, 99) < idle_pct) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
	endtask

	task automatic add_row(input logic [2:0] k, input logic [7:0] b, input bit typed,
			input bit has_beat, input logic [7:0] tx, input logic ind);
		table_rows.push_back('{k, b, typed, has_beat, tx, ind});
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
		while (expected_beats.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		if (idx == IDX_BLANK) blank_cnt = val;
		else blink_per = val;
	endtask

	task automatic send_random(input int count);
		int    sent;
		int    r;
		stim_t s;
		sent = 0;
		s.typed = 0;
		s.has_beat = 0;
		s.tx = 8'd0;
		s.ind = 1'b0;
		while (sent < count) begin
			r = $urandom_range(0, 99);
			s.b = 8'($urandom_range(0, 255));
			if (r < 30) begin
				s.k = KIND_RX;
				s.b = CH_HASH;
				send_item(s);
				sent++;
				for (int i = 0; i < NDIG; i++) begin
					r = $urandom_range(0, 99);
					if (r < 8) s.b = CH_AT;
					else if (r < 85) s.b = CH_ZERO + 8'($urandom_range(0, 9));
					else s.b = 8'($urandom_range(0, 255));
					send_item(s);
					sent++;
					if (s.b == CH_AT) break;
				end
			end else if (r < 42) begin
				s.k = KIND_RX;
				case ($urandom_range(0, 4))
					0: s.b = CH_AMP;
					1: s.b = CH_LPAREN;
					2: s.b = CH_RPAREN;
					3: s.b = CH_AT;
					default: ;
				endcase
				send_item(s);
				sent++;
			end else if (r < 56) begin
				s.k = KIND_SELECT;
				send_item(s);
				sent++;
			end else if (r < 72) begin
				s.k = $urandom_range(0, 1) ? KIND_UP : KIND_DOWN;
				send_item(s);
				sent++;
			end else if (r < 96) begin
				s.k = KIND_SCAN;
				send_item(s);
				sent++;
			end else begin
				s.k = 3'($urandom_range(KIND_SPARE_A, KIND_SPARE_C));
				send_item(s);
				sent++;
			end
		end
		push <= 1'b0;
	endtask

	task automatic check_field(input string name, input logic [7:0] exp_v,
			input logic [7:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin
		beat_t e;
		if (arst_n && pop && !empty) begin
			if (expected_beats.size() == 0) begin
				$display("%0t: result beat with nothing expected, expected none, actual %h",
					$time, {result_kind, tx_byte, digit_index, segments, indicator_on, last});
				mismatches++;
			end else begin
				e = expected_beats.pop_front();
				check_field("result_kind", 8'(e.rk), 8'(result_kind));
				check_field("tx_byte", e.tx, tx_byte);
				check_field("digit_index", 8'(e.idx), 8'(digit_index));
				check_field("segments", e.seg, segments);
				check_field("indicator_on", 8'(e.ind), 8'(indicator_on));
				check_field("last", 8'(e.lst), 8'(last));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		wait (arst_n === 1'b1);
		forever begin
			if (hold_out) begin
				pop <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_out = 0;
			end else if ($urandom_range(0, 99) < idle_pct) begin
				pop <= 1'b0;
				repeat ($urandom_range(1, 15)) @(posedge clk);
			end
			pop <= 1'b1;
			@(posedge clk);
		end
	end

	initial begin
		foreach (digits[i]) digits[i] = 4'd0;
		sel_pos = 3'd0;
		frame_pos = 3'd0;
		blink_cnt = 8'd0;
		ind_flag = 1'b0;
		blank_cnt = 8'd50;
		blink_per = 8'd100;

		add_row(KIND_SCAN,   8'h00,     0, 0, 8'd0,   1'b0);
		add_row(KIND_RX,     CH_AMP,    1, 1, CH_AMP, 1'b0);
		add_row(KIND_RX,     CH_LPAREN, 1, 0, 8'd0,   1'b0);
		add_row(KIND_RX,     CH_AMP,    1, 1, CH_AMP, 1'b1);
		add_row(KIND_RX,     CH_RPAREN, 1, 0, 8'd0,   1'b0);
		add_row(KIND_RX,     8'h00,     1, 0, 8'd0,   1'b0);
		add_row(KIND_RX,     8'hFF,     1, 0, 8'd0,   1'b0);
		add_row(KIND_SPARE_A, 8'hFF,    1, 0, 8'd0,   1'b0);
		add_row(KIND_SPARE_B, 8'h5A,    1, 0, 8'd0,   1'b0);
		add_row(KIND_SPARE_C, 8'h00,    1, 0, 8'd0,   1'b0);
		add_row(KIND_RX,     CH_HASH,   1, 0, 8'd0,   1'b0);
		add_row(KIND_RX,     CH_NINE,   0, 0, 8'd0,   1'b0);
		add_row(KIND_RX,     CH_ZERO,   0, 0, 8'd0,   1'b0);
		add_row(KIND_RX,     8'h78,     0, 0, 8'd0,   1'b0);
		add_row(KIND_RX,     8'h35,     0, 0, 8'd0,   1'b0);
		add_row(KIND_RX,     8'h31,     0, 0, 8'd0,   1'b0);
		add_row(KIND_UP,     8'h00,     0, 0, 8'd0,   1'b0);
		add_row(KIND_SELECT, 8'h00,     0, 0, 8'd0,   1'b0);
		add_row(KIND_UP,     8'h00,     0, 0, 8'd0,   1'b0);
		add_row(KIND_DOWN,   8'h00,     0, 0, 8'd0,   1'b0);
		add_row(KIND_SCAN,   8'h00,     0, 0, 8'd0,   1'b0);
		add_row(KIND_RX,     CH_HASH,   0, 0, 8'd0,   1'b0);
		add_row(KIND_RX,     CH_AT,     0, 0, 8'd0,   1'b0);
		add_row(KIND_DOWN,   8'h00,     0, 0, 8'd0,   1'b0);

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		idle_pct = 15;
		foreach (table_rows[i]) send_item(table_rows[i]);
		push <= 1'b0;
		hold_out = 1;
		send_random(30);

		write_reg(IDX_BLANK, 8'd0);
		write_reg(IDX_PERIOD, 8'd0);
		idle_pct = 30;
		send_random(25);

		write_reg(IDX_BLANK, 8'd255);
		write_reg(IDX_PERIOD, 8'd255);
		idle_pct = 0;
		send_random(25);

		write_reg(IDX_BLANK, 8'd2);
		write_reg(IDX_PERIOD, 8'd6);
		idle_pct = 20;
		send_random(30);

		write_reg(IDX_PERIOD, 8'd3);
		write_reg(IDX_BLANK, 8'd7);
		idle_pct = 0;
		send_random(26);

		while (expected_beats.size() != 0) @(posedge clk);
		repeat (END_CYCLES) @(posedge clk);
		if (expected_beats.size() != 0) begin
			$display("%0t: %0d expected beats never arrived, expected 0, actual %0d",
				$time, expected_beats.size(), expected_beats.size());
			mismatches++;
		end
		if (mismatches == 0) $display("status: pass");
		else $display("status: fail");
		$finish;
	end

endmodule
